>>> design/cimu_pkg.sv
package cimu_pkg;

    // Queue depths used as parameter defaults on the top level.
    localparam int CMD_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 4;

    // Configuration register indexes.
    localparam logic CFG_SENSOR_MODE = 1'b0;
    localparam logic CFG_ABS_ENABLE  = 1'b1;

    // Sensor type codes; the unused code behaves as none.
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_STD    = 2'd1;
    localparam logic [1:0] MODE_ALT    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Frame identifiers.
    localparam logic [10:0] ID_STD_YAWLAT = 11'h174;
    localparam logic [10:0] ID_STD_LON    = 11'h178;
    localparam logic [10:0] ID_STD_VERT   = 11'h17C;
    localparam logic [10:0] ID_ALT_YAWLAT = 11'h150;
    localparam logic [10:0] ID_ALT_LON    = 11'h151;
    localparam logic [10:0] ID_ABS        = 11'd416;

    // Axis codes.
    localparam logic [1:0] AX_LAT  = 2'd0;
    localparam logic [1:0] AX_LON  = 2'd1;
    localparam logic [1:0] AX_VERT = 2'd2;
    localparam logic [1:0] AX_YAW  = 2'd3;

    // Scale factors, round(quant * 2^32).
    localparam logic signed [28:0] K_YAW  = 29'sd21474836;
    localparam logic signed [28:0] K_ACC  = 29'sd547179;
    localparam logic signed [28:0] K_ABSA = 29'sd107374182;
    localparam logic signed [28:0] K_ABSY = 29'sd214748365;

    // Rounding bias added before the 16-bit shift.
    localparam logic signed [47:0] ROUND_BIAS = 48'sd32768;

    // Frame classes handed from the front end to the back end.
    typedef enum logic [1:0] {
        KIND_YAWLAT = 2'd0,
        KIND_LON    = 2'd1,
        KIND_VERT   = 2'd2,
        KIND_ABS    = 2'd3
    } t_kind;

    // One classified frame: its class, up to three raw samples, its time.
    typedef struct packed {
        t_kind             kind;
        logic [2:0][15:0]  raw;
        logic [31:0]       stamp;
    } t_cmd;

    // One sensor update as it leaves the block.
    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] value;
        logic [31:0]        stamp;
        logic               last;
    } t_update;

    // Number of updates a frame class produces.
    function automatic logic [1:0] kind_count(input t_kind kind);
        logic [1:0] cnt;
        unique case (kind)
            KIND_YAWLAT: cnt = 2'd2;
            KIND_LON:    cnt = 2'd1;
            KIND_VERT:   cnt = 2'd1;
            KIND_ABS:    cnt = 2'd3;
            default:     cnt = 2'd1;
        endcase
        return cnt;
    endfunction

    // Axis of a given update within a frame class.
    function automatic logic [1:0] slot_axis(input t_kind kind, input logic [1:0] slot);
        logic [1:0] ax;
        unique case (kind)
            KIND_YAWLAT: ax = (slot == 2'd0) ? AX_YAW : AX_LAT;
            KIND_LON:    ax = AX_LON;
            KIND_VERT:   ax = AX_VERT;
            KIND_ABS:    ax = (slot == 2'd0) ? AX_LAT : ((slot == 2'd1) ? AX_LON : AX_YAW);
            default:     ax = AX_LAT;
        endcase
        return ax;
    endfunction

    // Scale factor of a given update within a frame class.
    function automatic logic signed [28:0] slot_k(input t_kind kind, input logic [1:0] slot);
        logic signed [28:0] k;
        unique case (kind)
            KIND_YAWLAT: k = (slot == 2'd0) ? K_YAW : K_ACC;
            KIND_LON:    k = K_ACC;
            KIND_VERT:   k = K_ACC;
            KIND_ABS:    k = (slot == 2'd2) ? K_ABSY : K_ABSA;
            default:     k = K_ACC;
        endcase
        return k;
    endfunction

endpackage

>>> design/cimu_fifo.sv
module cimu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [WIDTH-1:0]             o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd];
    assign o_count   = r_count;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Storage holds payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/cimu_front.sv
module cimu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [1:0]      i_cfg_data,
    input  logic            i_push,
    input  logic [10:0]     i_frame_id,
    input  logic [63:0]     i_payload,
    input  logic [31:0]     i_timestamp,
    output logic            o_full,
    input  logic            i_cmd_full,
    output logic            o_cmd_push,
    output cimu_pkg::t_cmd  o_cmd
);

    import cimu_pkg::*;

    logic [1:0]  r_sensor_mode;
    logic        r_abs_enable;
    logic        w_match;
    t_kind       w_kind;
    logic [15:0] w_word0;
    logic [15:0] w_word4;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_mode <= MODE_NONE;
            r_abs_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SENSOR_MODE: r_sensor_mode <= i_cfg_data;
                CFG_ABS_ENABLE:  r_abs_enable  <= i_cfg_data[0];
                default:         r_abs_enable  <= r_abs_enable;
            endcase
        end
    end

    // Classify the frame by sensor type and identifier.
    always_comb begin
        w_match = 1'b0;
        w_kind  = KIND_LON;
        priority if (r_sensor_mode == MODE_STD) begin
            priority if (i_frame_id == ID_STD_YAWLAT) begin
                w_match = 1'b1;
                w_kind  = KIND_YAWLAT;
            end else if (i_frame_id == ID_STD_LON) begin
                w_match = 1'b1;
                w_kind  = KIND_LON;
            end else if (i_frame_id == ID_STD_VERT) begin
                w_match = 1'b1;
                w_kind  = KIND_VERT;
            end else begin
                w_match = 1'b0;
            end
        end else if (r_sensor_mode == MODE_ALT) begin
            priority if (i_frame_id == ID_ALT_YAWLAT) begin
                w_match = 1'b1;
                w_kind  = KIND_YAWLAT;
            end else if (i_frame_id == ID_ALT_LON) begin
                w_match = 1'b1;
                w_kind  = KIND_LON;
            end else begin
                w_match = 1'b0;
            end
        end else begin
            w_match = r_abs_enable && (i_frame_id == ID_ABS);
            w_kind  = KIND_ABS;
        end
    end

    // Offset-binary words: subtracting 0x8000 flips the top bit.
    assign w_word0 = {~i_payload[15], i_payload[14:0]};
    assign w_word4 = {~i_payload[47], i_payload[46:32]};

    // Extract the raw samples in update order.
    always_comb begin
        o_cmd.kind  = w_kind;
        o_cmd.stamp = i_timestamp;
        o_cmd.raw   = '0;
        unique case (w_kind)
            KIND_YAWLAT: begin
                o_cmd.raw[0] = w_word0;
                o_cmd.raw[1] = w_word4;
            end
            KIND_LON, KIND_VERT: begin
                o_cmd.raw[0] = w_word4;
            end
            KIND_ABS: begin
                o_cmd.raw[0] = {{4{i_payload[27]}}, i_payload[27:16]};
                o_cmd.raw[1] = {{4{i_payload[39]}}, i_payload[39:28]};
                o_cmd.raw[2] = {{4{i_payload[51]}}, i_payload[51:40]};
            end
            default: begin
                o_cmd.raw[0] = w_word0;
            end
        endcase
    end

    // Frames that decode to nothing are accepted and dropped here.
    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push && !i_cmd_full && w_match;

endmodule

>>> design/cimu_back.sv
module cimu_back #(
    parameter int OUT_DEPTH = cimu_pkg::OUT_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_empty,
    input  cimu_pkg::t_cmd                    i_cmd,
    output logic                              o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]    i_out_count,
    output logic                              o_upd_push,
    output cimu_pkg::t_update                 o_upd
);

    import cimu_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH+1);

    logic [1:0]         r_slot;
    logic               r_mul_vld;
    logic signed [47:0] r_prod;
    logic [1:0]         r_axis;
    logic [31:0]        r_stamp;
    logic               r_last;
    logic               w_credit;
    logic               w_issue;
    logic               w_last;
    logic signed [15:0] w_raw;
    logic signed [28:0] w_k;
    logic signed [47:0] w_prod;
    logic signed [47:0] w_round;

    // Issue only while the result queue has room for everything in flight.
    assign w_credit  = ((CW+1)'(i_out_count) + (CW+1)'(r_mul_vld)) < (CW+1)'(OUT_DEPTH);
    assign w_issue   = !i_cmd_empty && w_credit;
    assign w_last    = (r_slot == kind_count(i_cmd.kind) - 2'd1);
    assign o_cmd_pop = w_issue && w_last;

    // Pick the sample and scale factor of the current update.
    always_comb begin
        unique case (r_slot)
            2'd0:    w_raw = $signed(i_cmd.raw[0]);
            2'd1:    w_raw = $signed(i_cmd.raw[1]);
            2'd2:    w_raw = $signed(i_cmd.raw[2]);
            default: w_raw = $signed(i_cmd.raw[0]);
        endcase
        w_k    = slot_k(i_cmd.kind, r_slot);
        w_prod = w_raw * w_k;
    end

    // Update counter within the current frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_mul_vld <= 1'b0;
        end else begin
            r_mul_vld <= w_issue;
            if (w_issue) begin
                r_slot <= w_last ? 2'd0 : r_slot + 2'd1;
            end
        end
    end

    // Product register with the update's side fields.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_prod  <= w_prod;
            r_axis  <= slot_axis(i_cmd.kind, r_slot);
            r_stamp <= i_cmd.stamp;
            r_last  <= w_last;
        end
    end

    // Round and drop the 16 fraction bits.
    assign w_round     = r_prod + ROUND_BIAS;
    assign o_upd_push  = r_mul_vld;
    assign o_upd.axis  = r_axis;
    assign o_upd.value = w_round[47:16];
    assign o_upd.stamp = r_stamp;
    assign o_upd.last  = r_last;

endmodule

>>> design/can_imu_frame_decoder_unit.sv
// Inertial sensor decoder for received CAN frames.
// Input side is a queue: drive a frame (identifier, eight payload bytes,
// timestamp) with push; the frame is taken at an edge where push is high
// and full is low. Frames that match no configured sensor are taken and
// dropped. Output side is a queue: while empty is low the oldest update
// (axis, Q15.16 value, stamp, last) is on the outputs, and it is removed
// at an edge where pop is high.
// A frame yields up to three updates. While the result queue has room, the
// back end runs one multiply per cycle, one per update, so single-update
// frames flow at one frame per cycle and a frame with more updates holds
// the back end for one multiply per update.
// Configuration is a plain write port, register 0 the sensor type and
// register 1 the ABS source enable; write it only while the block is idle.
// Reset empties both queues and clears the configuration to no sensor with
// the ABS source disabled. When the receiver stops popping, the result
// queue fills, the back end halts, the command queue fills and full rises.
module can_imu_frame_decoder_unit #(
    parameter int CMD_DEPTH = cimu_pkg::CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = cimu_pkg::OUT_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [1:0]         i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [10:0]        i_frame_id,
    input  logic [63:0]        i_payload,
    input  logic [31:0]        i_timestamp,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_axis,
    output logic signed [31:0] o_value,
    output logic [31:0]        o_stamp,
    output logic               o_last
);

    import cimu_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int UPD_W = $bits(t_update);

    logic                           w_cmd_push;
    logic                           w_cmd_full;
    logic                           w_cmd_empty;
    logic                           w_cmd_pop;
    t_cmd                           w_cmd_in;
    logic [CMD_W-1:0]               w_cmd_out;
    logic [$clog2(CMD_DEPTH+1)-1:0] w_cmd_count;
    logic                           w_upd_push;
    t_update                        w_upd_in;
    logic [UPD_W-1:0]               w_upd_out;
    t_update                        w_upd;
    logic                           w_out_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] w_out_count;

    // Front end: configuration and frame classification.
    cimu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_frame_id  (i_frame_id),
        .i_payload   (i_payload),
        .i_timestamp (i_timestamp),
        .o_full      (full),
        .i_cmd_full  (w_cmd_full),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_cmd_in)
    );

    // Queue of classified frames.
    cimu_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_full  (w_cmd_full),
        .o_empty (w_cmd_empty),
        .o_data  (w_cmd_out),
        .o_count (w_cmd_count)
    );

    // Back end: one scaled update per cycle while the result queue has room.
    cimu_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (t_cmd'(w_cmd_out)),
        .o_cmd_pop   (w_cmd_pop),
        .i_out_count (w_out_count),
        .o_upd_push  (w_upd_push),
        .o_upd       (w_upd_in)
    );

    // Result queue.
    cimu_fifo #(
        .WIDTH (UPD_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_upd_push),
        .i_data  (w_upd_in),
        .i_pop   (pop),
        .o_full  (w_out_full),
        .o_empty (empty),
        .o_data  (w_upd_out),
        .o_count (w_out_count)
    );

    assign w_upd   = t_update'(w_upd_out);
    assign o_axis  = w_upd.axis;
    assign o_value = w_upd.value;
    assign o_stamp = w_upd.stamp;
    assign o_last  = w_upd.last;

`ifndef SYNTHESIS
    // The back end never writes an update that the result queue cannot hold.
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_push |-> !w_out_full)
        else $error("result queue written while full");

    // A frame leaves the command queue only when one is there.
    a_no_cmd_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command queue popped while empty");

    // The front end never enqueues into a full command queue.
    a_no_cmd_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> (!w_cmd_full && w_cmd_count != CMD_DEPTH[$bits(w_cmd_count)-1:0]))
        else $error("command queue written while full");

    // An update enters the result queue in the cycle after the back end
    // draws a frame from the command queue.
    a_pop_then_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |=> w_upd_push)
        else $error("frame retired without producing its update");
`endif

endmodule

>>> tb/can_imu_frame_decoder_checker.sv
`timescale 1ns / 100ps

// Watches the frame and update channels of the decoder, predicts the updates
// of every accepted frame and compares each accepted update with the oldest
// prediction. It keeps its own copy of the configuration registers.
module can_imu_frame_decoder_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [10:0]        i_frame_id,
    input  logic [63:0]        i_payload,
    input  logic [31:0]        i_timestamp,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic [1:0]         i_axis,
    input  logic signed [31:0] i_value,
    input  logic [31:0]        i_stamp,
    input  logic               i_last,
    output int                 o_errors,
    output int                 o_pending
);

    import cimu_pkg::*;

    logic [1:0] sensor_mode_q;
    logic       abs_enable_q;
    t_update    expected_updates[$];
    int         err_cnt  = 0;
    int         pend_cnt = 0;

    assign o_errors  = err_cnt;
    assign o_pending = pend_cnt;

    // Q15.16 scaling with round-half-up and a floor shift.
    function automatic logic signed [31:0] q16_scale(input longint raw, input longint k);
        longint prod;
        prod = raw * k + 64'sd32768;
        return prod[47:16];
    endfunction

    // A 16-bit offset-binary word reduced by its midpoint.
    function automatic longint offset_word(input logic [15:0] w);
        return longint'(w) - 64'sd32768;
    endfunction

    // A 12-bit two's complement field, sign extended.
    function automatic longint sext12(input logic [11:0] f);
        return longint'($signed(f));
    endfunction

    // Queues one predicted update.
    task automatic add_update(input logic [1:0] axis, input logic signed [31:0] value,
                              input logic [31:0] stamp, input logic last);
        t_update upd;
        upd.axis  = axis;
        upd.value = value;
        upd.stamp = stamp;
        upd.last  = last;
        expected_updates.push_back(upd);
    endtask

    // Works out the updates that one accepted frame causes.
    task automatic predict_updates(input logic [10:0] id, input logic [63:0] pl,
                                   input logic [31:0] ts);
        logic std_mode;
        logic alt_mode;
        std_mode = (sensor_mode_q == MODE_STD);
        alt_mode = (sensor_mode_q == MODE_ALT);
        if ((std_mode && id == ID_STD_YAWLAT) || (alt_mode && id == ID_ALT_YAWLAT)) begin
            add_update(AX_YAW, q16_scale(offset_word(pl[15:0]), longint'(K_YAW)), ts, 1'b0);
            add_update(AX_LAT, q16_scale(offset_word(pl[47:32]), longint'(K_ACC)), ts, 1'b1);
        end else if ((std_mode && id == ID_STD_LON) || (alt_mode && id == ID_ALT_LON)) begin
            add_update(AX_LON, q16_scale(offset_word(pl[47:32]), longint'(K_ACC)), ts, 1'b1);
        end else if (std_mode && id == ID_STD_VERT) begin
            add_update(AX_VERT, q16_scale(offset_word(pl[47:32]), longint'(K_ACC)), ts, 1'b1);
        end else if (!std_mode && !alt_mode && abs_enable_q && id == ID_ABS) begin
            // No sensor type set, so the ABS module frame is decoded.
            add_update(AX_LAT, q16_scale(sext12(pl[27:16]), longint'(K_ABSA)), ts, 1'b0);
            add_update(AX_LON, q16_scale(sext12(pl[39:28]), longint'(K_ABSA)), ts, 1'b0);
            add_update(AX_YAW, q16_scale(sext12(pl[51:40]), longint'(K_ABSY)), ts, 1'b1);
        end
    endtask

    // Samples every channel at the rising edge.
    always @(posedge i_clk) begin
        t_update exp_upd;
        if (!i_rst_n) begin
            sensor_mode_q = MODE_NONE;
            abs_enable_q  = 1'b0;
            expected_updates.delete();
        end else begin
            // Compare an accepted update transaction with the oldest prediction.
            if (i_pop && !i_empty) begin
                if (expected_updates.size() == 0) begin
                    $error("update with no expected transaction: axis %0d value %0d",
                           i_axis, i_value);
                    err_cnt++;
                end else begin
                    exp_upd = expected_updates.pop_front();
                    if (i_axis !== exp_upd.axis) begin
                        $error("axis: expected %0d, actual %0d", exp_upd.axis, i_axis);
                        err_cnt++;
                    end
                    if (i_value !== exp_upd.value) begin
                        $error("value: expected %0d, actual %0d", exp_upd.value, i_value);
                        err_cnt++;
                    end
                    if (i_stamp !== exp_upd.stamp) begin
                        $error("stamp: expected %h, actual %h", exp_upd.stamp, i_stamp);
                        err_cnt++;
                    end
                    if (i_last !== exp_upd.last) begin
                        $error("last: expected %0d, actual %0d", exp_upd.last, i_last);
                        err_cnt++;
                    end
                end
            end
            // Track register writes.
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SENSOR_MODE) begin
                    sensor_mode_q = i_cfg_data;
                end else begin
                    abs_enable_q = i_cfg_data[0];
                end
            end
            // Predict the updates of an accepted frame transaction.
            if (i_push && !i_full) begin
                predict_updates(i_frame_id, i_payload, i_timestamp);
            end
        end
        pend_cnt = expected_updates.size();
    end

endmodule

>>> tb/tb_can_imu_frame_decoder_unit.sv
`timescale 1ns / 100ps

module tb_can_imu_frame_decoder_unit;

    import cimu_pkg::*;

    localparam int MAX_GAP       = 17;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_idx   = 1'b0;
    logic [1:0]         cfg_data  = 2'd0;
    logic               push      = 1'b0;
    logic [10:0]        frame_id  = 11'd0;
    logic [63:0]        payload   = 64'd0;
    logic [31:0]        timestamp = 32'd0;
    logic               pop       = 1'b0;
    logic               full;
    logic               empty;
    logic [1:0]         axis;
    logic signed [31:0] value;
    logic [31:0]        stamp;
    logic               last;
    int                 errors;
    int                 pending;
    int                 cycle_cnt = 0;
    logic               tx_idle   = 1'b1;
    logic               rx_idle   = 1'b1;
    logic               hold_req  = 1'b0;

    can_imu_frame_decoder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .push        (push),
        .full        (full),
        .i_frame_id  (frame_id),
        .i_payload   (payload),
        .i_timestamp (timestamp),
        .empty       (empty),
        .pop         (pop),
        .o_axis      (axis),
        .o_value     (value),
        .o_stamp     (stamp),
        .o_last      (last)
    );

    can_imu_frame_decoder_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_push      (push),
        .i_full      (full),
        .i_frame_id  (frame_id),
        .i_payload   (payload),
        .i_timestamp (timestamp),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_axis      (axis),
        .i_value     (value),
        .i_stamp     (stamp),
        .i_last      (last),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_can_imu_frame_decoder_unit: errors");
            $finish;
        end
    end

    // A random 16-bit word, often one of the extremes.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // A random 12-bit field, often one of the extremes.
    function automatic logic [11:0] pick_field12();
        case ($urandom_range(0, 7))
            0:       return 12'h000;
            1:       return 12'hFFF;
            2:       return 12'h800;
            3:       return 12'h7FF;
            default: return 12'($urandom);
        endcase
    endfunction

    // Payload of a sensor frame: yaw word in bytes 0..1, accel word in bytes 4..5.
    function automatic logic [63:0] sensor_payload(input logic [15:0] yaw_w,
                                                   input logic [15:0] acc_w);
        logic [63:0] p;
        p        = {$urandom, $urandom};
        p[15:0]  = yaw_w;
        p[47:32] = acc_w;
        return p;
    endfunction

    // Payload of an ABS module frame with three 12-bit fields.
    function automatic logic [63:0] abs_payload(input logic [11:0] f_lat,
                                                input logic [11:0] f_lon,
                                                input logic [11:0] f_yaw);
        logic [63:0] p;
        p        = {$urandom, $urandom};
        p[27:16] = f_lat;
        p[39:28] = f_lon;
        p[51:40] = f_yaw;
        return p;
    endfunction

    // Offers one frame transaction, after a random gap while tx_idle is set, and waits for acceptance.
    task automatic send_frame(input logic [10:0] id, input logic [63:0] pl,
                              input logic [31:0] ts);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        frame_id  <= id;
        payload   <= pl;
        timestamp <= ts;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    // Waits until every predicted update has been received and the block is quiet.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write transaction.
    task automatic write_reg(input logic idx, input logic [1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Reconfigures the block once it is idle; bit 1 of the enable write is junk.
    task automatic set_config(input logic [1:0] mode, input logic abs_en);
        wait_idle();
        write_reg(CFG_SENSOR_MODE, mode);
        write_reg(CFG_ABS_ENABLE, {1'($urandom), abs_en});
    endtask

    // One random frame: mostly identifiers that decode in this setting, where any do.
    task automatic send_random_frame(input logic [1:0] mode, input logic abs_en);
        logic [10:0] id;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel < 8 && mode == MODE_STD) begin
            case ($urandom_range(0, 2))
                0:       id = ID_STD_YAWLAT;
                1:       id = ID_STD_LON;
                default: id = ID_STD_VERT;
            endcase
        end else if (sel < 8 && mode == MODE_ALT) begin
            id = $urandom_range(0, 1) ? ID_ALT_YAWLAT : ID_ALT_LON;
        end else if (sel < 8 && abs_en) begin
            id = ID_ABS;
        end else if (sel < 9) begin
            // Known identifiers of any setting.
            case ($urandom_range(0, 5))
                0:       id = ID_STD_YAWLAT;
                1:       id = ID_STD_LON;
                2:       id = ID_STD_VERT;
                3:       id = ID_ALT_YAWLAT;
                4:       id = ID_ALT_LON;
                default: id = ID_ABS;
            endcase
        end else begin
            id = 11'($urandom_range(0, 2047));
        end
        if (id == ID_ABS) begin
            send_frame(id, abs_payload(pick_field12(), pick_field12(), pick_field12()),
                       $urandom);
        end else if ($urandom_range(0, 3) == 0) begin
            send_frame(id, {$urandom, $urandom}, $urandom);
        end else begin
            send_frame(id, sensor_payload(pick_word(), pick_word()), $urandom);
        end
    endtask

    // One random phase under a fixed configuration.
    task automatic run_phase(input int p, input logic [1:0] mode, input logic abs_en,
                             input int count);
        set_config(mode, abs_en);
        tx_idle = (p % 3 != 0);
        rx_idle = (p % 4 != 1);
        // Let the block fill up while the receiver holds off.
        if (p == 0) hold_req = 1'b1;
        repeat (count) send_random_frame(mode, abs_en);
    endtask

    // Receiver: pops update transactions, after random gaps while rx_idle is set, with one long hold-off.
    initial begin : receiver
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            repeat (gap) begin
                pop <= 1'b0;
                @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    // Stimulus and verdict.
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset setting: nothing decodes, not even the ABS frame.
        send_frame(ID_ABS, {$urandom, $urandom}, $urandom);
        send_frame(11'd0, 64'd0, 32'd0);
        send_frame(11'h7FF, {64{1'b1}}, 32'hFFFF_FFFF);

        // ABS frames with no sensor type set, field extremes, and a standard identifier that does not decode.
        set_config(MODE_NONE, 1'b1);
        send_frame(ID_ABS, abs_payload(12'h800, 12'h7FF, 12'h000), 32'hFFFF_FFFF);
        send_frame(ID_ABS, abs_payload(12'hFFF, 12'h001, 12'h800), 32'd0);
        send_frame(ID_ABS, {64{1'b1}}, $urandom);
        send_frame(ID_ABS, 64'd0, $urandom);
        send_frame(ID_STD_YAWLAT, sensor_payload(16'h0000, 16'hFFFF), $urandom);

        // The unused mode code behaves as none.
        set_config(MODE_UNUSED, 1'b1);
        send_frame(ID_ABS, abs_payload(12'h7FF, 12'h7FF, 12'h7FF), $urandom);
        send_frame(ID_STD_LON, sensor_payload(16'h0000, 16'h0000), $urandom);

        // Standard identifiers, word extremes; the ABS frame is ignored here.
        set_config(MODE_STD, 1'b1);
        send_frame(ID_STD_YAWLAT, sensor_payload(16'h0000, 16'hFFFF), $urandom);
        send_frame(ID_STD_YAWLAT, sensor_payload(16'hFFFF, 16'h0000), $urandom);
        send_frame(ID_STD_YAWLAT, sensor_payload(16'h8000, 16'h8000), $urandom);
        send_frame(ID_STD_LON, sensor_payload(16'h1234, 16'h7FFF), $urandom);
        send_frame(ID_STD_VERT, sensor_payload(16'hFFFF, 16'h0000), $urandom);
        send_frame(ID_ALT_YAWLAT, sensor_payload(16'h0000, 16'h0000), $urandom);
        send_frame(ID_ABS, abs_payload(12'h800, 12'h800, 12'h800), $urandom);

        // Alternate identifiers; standard-only identifiers are unknown here.
        set_config(MODE_ALT, 1'b0);
        send_frame(ID_ALT_YAWLAT, sensor_payload(16'hFFFF, 16'h0000), $urandom);
        send_frame(ID_ALT_LON, sensor_payload(16'h0000, 16'hFFFF), $urandom);
        send_frame(ID_STD_YAWLAT, sensor_payload(16'h0000, 16'h0000), $urandom);
        send_frame(ID_STD_VERT, sensor_payload(16'h0000, 16'h0000), $urandom);

        // Random phases across all settings.
        run_phase(0, MODE_STD, 1'b0, 90);
        run_phase(1, MODE_ALT, 1'b1, 90);
        run_phase(2, MODE_NONE, 1'b1, 80);
        run_phase(3, MODE_UNUSED, 1'b1, 60);
        run_phase(4, MODE_STD, 1'b1, 90);
        run_phase(5, MODE_ALT, 1'b0, 90);
        run_phase(6, MODE_NONE, 1'b0, 20);
        run_phase(7, MODE_UNUSED, 1'b0, 20);

        // Drain and give the verdict.
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_can_imu_frame_decoder_unit: clean");
        end else begin
            $display("tb_can_imu_frame_decoder_unit: errors");
        end
        $finish;
    end

endmodule

>>> can_imu_frame_decoder_unit.f
design/cimu_pkg.sv
design/cimu_fifo.sv
design/cimu_front.sv
design/cimu_back.sv
design/can_imu_frame_decoder_unit.sv
tb/can_imu_frame_decoder_checker.sv
tb/tb_can_imu_frame_decoder_unit.sv
